/* hdl/sara_pkg.sv */
// Shared types, constants and a helper function for the square atlas region allocator.
`timescale 1ns / 1ps

package sara_pkg;

   localparam int SIZE_W      = 16;
   localparam int NEED_W      = 5;
   localparam int POS_W       = 10;
   localparam int CNT_W       = 2;
   localparam int TDATA_IN_W  = 16;
   localparam int TDATA_OUT_W = 24;

   localparam logic [CNT_W-1:0] LEVEL_SLOTS = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FRESH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_LOAD,
      ST_SPLIT,
      ST_DONE
   } state_type;

   // Request from the sequencer to the per-level list bookkeeping.
   typedef struct packed {
      logic clear;
      logic pop;
      logic push;
   } lvl_cmd_type;

   // Ring state of the addressed level's free list.
   typedef struct packed {
      logic             empty;
      logic [CNT_W-1:0] head;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] tail;
   } lvl_stat_type;

   // Level whose side 2^level is the smallest power of two not below size.
   function automatic logic [NEED_W-1:0] size_level(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] m;
      logic [NEED_W-1:0] lev;
      m   = (size == '0) ? '0 : size - SIZE_W'(1);
      lev = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (m[i]) begin
            lev = NEED_W'(i + 1);
         end
      end
      return lev;
   endfunction

endpackage

/* hdl/square_atlas_region_allocator.sv */
// Top level: request sequencer, result register and the free-list storage.
//
//   group  dir  fields (tdata / tuser, lowest bit first)
//   req    in   tdata: block_size[15:0]           tuser: operation
//   rsp    out  tdata: pos_x[9:0], pos_y[19:10]   tuser: success
//
// A word served from its own level is popped in SEARCH, loaded in LOAD and answered
// from DONE. Each empty level searched moves the search up a level and each level split
// adds three quadrant writes. A fresh atlas or a too large size goes straight to DONE;
// a full atlas searches up to the top level first. Reset restores the empty atlas at
// once. The next word is taken in IDLE after the result is loaded; a result held by
// rsp_tready stalls the following one.
`timescale 1ns / 1ps

module square_atlas_region_allocator #(
   parameter int ATLAS_LEVELS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [sara_pkg::TDATA_IN_W-1:0]  req_tdata,   // block_size[15:0]
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [sara_pkg::TDATA_OUT_W-1:0] rsp_tdata,   // pos_x[9:0], pos_y[19:10], zero[23:20]
   output logic        rsp_tuser    // success
);

   localparam int LW = $clog2(ATLAS_LEVELS + 1);
   localparam int CW = ATLAS_LEVELS;
   localparam logic [LW-1:0] TOP_LEVEL = LW'(ATLAS_LEVELS);

   sara_pkg::state_type    state_ff, state_in;
   sara_pkg::lvl_cmd_type  lvl_cmd;
   sara_pkg::lvl_stat_type lvl_stat;

   logic [LW-1:0] lev_ff, lev_in;
   logic [LW-1:0] need_ff, need_in;
   logic [1:0]    quad_ff, quad_in;
   logic [CW-1:0] cx_ff, cx_in;
   logic [CW-1:0] cy_ff, cy_in;
   logic          ok_ff, ok_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_succ_ff, rsp_succ_in;
   logic [sara_pkg::POS_W-1:0] rsp_x_ff, rsp_x_in;
   logic [sara_pkg::POS_W-1:0] rsp_y_ff, rsp_y_in;

   logic                    req_fire;
   logic                    out_free;
   logic [sara_pkg::NEED_W-1:0] need_lvl;
   logic                    too_large;
   logic [CW-1:0]           half;
   logic [CW-1:0]           push_x, push_y;
   logic                    ram_wr_en, ram_rd_en;
   logic [LW+1:0]           ram_wr_addr, ram_rd_addr;
   logic [2*CW-1:0]         ram_wr_data, ram_rd_data;

   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign need_lvl  = sara_pkg::size_level(req_tdata);
   assign too_large = (need_lvl > sara_pkg::NEED_W'(ATLAS_LEVELS));
   assign half      = CW'(1) << lev_ff;

   sara_level_table #(
      .ATLAS_LEVELS(ATLAS_LEVELS)
   ) u_level_table (
      .clock  (clock),
      .reset  (reset),
      .cmd    (lvl_cmd),
      .lvl_idx(lev_ff),
      .stat   (lvl_stat)
   );

   sara_slot_ram #(
      .ATLAS_LEVELS(ATLAS_LEVELS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sara_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == sara_pkg::OP_FRESH || too_large) begin
                  state_in = sara_pkg::ST_DONE;
               end else begin
                  state_in = sara_pkg::ST_SEARCH;
               end
            end
         end
         sara_pkg::ST_SEARCH: begin
            if (!lvl_stat.empty) begin
               state_in = sara_pkg::ST_LOAD;
            end else if (lev_ff == TOP_LEVEL) begin
               state_in = sara_pkg::ST_DONE;
            end
         end
         sara_pkg::ST_LOAD: begin
            state_in = (lev_ff == need_ff) ? sara_pkg::ST_DONE : sara_pkg::ST_SPLIT;
         end
         sara_pkg::ST_SPLIT: begin
            if (quad_ff == 2'd2 && lev_ff == need_ff) begin
               state_in = sara_pkg::ST_DONE;
            end
         end
         sara_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = sara_pkg::ST_IDLE;
            end
         end
         default: state_in = sara_pkg::ST_IDLE;
      endcase
   end

   // Datapath and control outputs.
   always_comb begin
      lev_in      = lev_ff;
      need_in     = need_ff;
      quad_in     = quad_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      ok_in       = ok_ff;
      lvl_cmd     = '0;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = {lev_ff, lvl_stat.head};
      ram_wr_addr = {lev_ff, lvl_stat.tail};
      push_x      = cx_ff;
      push_y      = cy_ff;
      req_tready  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_succ_in  = rsp_succ_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;

      // Quadrants are queued right, below, then diagonal; top-left is kept.
      case (quad_ff)
         2'd0:    push_x = cx_ff + half;
         2'd1:    push_y = cy_ff + half;
         default: begin
            push_x = cx_ff + half;
            push_y = cy_ff + half;
         end
      endcase
      ram_wr_data = {push_y, push_x};

      case (state_ff)
         sara_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ok_in      = 1'b0;
            if (req_fire) begin
               if (req_tuser == sara_pkg::OP_FRESH) begin
                  lvl_cmd.clear = 1'b1;
               end else if (!too_large) begin
                  need_in = LW'(need_lvl);
                  lev_in  = LW'(need_lvl);
               end
            end
         end
         sara_pkg::ST_SEARCH: begin
            if (!lvl_stat.empty) begin
               lvl_cmd.pop = 1'b1;
               ram_rd_en   = 1'b1;
            end else if (lev_ff != TOP_LEVEL) begin
               lev_in = lev_ff + LW'(1);
            end
         end
         sara_pkg::ST_LOAD: begin
            ok_in = 1'b1;
            // The top level only ever holds the whole atlas at the origin.
            if (lev_ff == TOP_LEVEL) begin
               cx_in = '0;
               cy_in = '0;
            end else begin
               cx_in = ram_rd_data[CW-1:0];
               cy_in = ram_rd_data[2*CW-1:CW];
            end
            if (lev_ff != need_ff) begin
               lev_in  = lev_ff - LW'(1);
               quad_in = 2'd0;
            end
         end
         sara_pkg::ST_SPLIT: begin
            lvl_cmd.push = 1'b1;
            ram_wr_en    = (lvl_stat.count < sara_pkg::LEVEL_SLOTS);
            if (quad_ff == 2'd2) begin
               quad_in = 2'd0;
               if (lev_ff != need_ff) begin
                  lev_in = lev_ff - LW'(1);
               end
            end else begin
               quad_in = quad_ff + 2'd1;
            end
         end
         sara_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_succ_in  = ok_ff;
               rsp_x_in     = ok_ff ? sara_pkg::POS_W'(cx_ff) : '0;
               rsp_y_in     = ok_ff ? sara_pkg::POS_W'(cy_ff) : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sara_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ok_ff        <= 1'b0;
         quad_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ok_ff        <= ok_in;
         quad_ff      <= quad_in;
      end
   end

   always_ff @(posedge clock) begin
      lev_ff      <= lev_in;
      need_ff     <= need_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      rsp_succ_ff <= rsp_succ_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_succ_ff;
   assign rsp_tdata  = {4'b0000, rsp_y_ff, rsp_x_ff};

`ifndef SYNTHESIS
   a_fresh_fails: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == sara_pkg::OP_FRESH) |=>
      (state_ff == sara_pkg::ST_DONE && !ok_ff))
      else $error("fresh atlas request did not go straight to a failed result");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      lvl_cmd.pop |-> (lvl_stat.count != '0))
      else $error("pop issued on an empty level");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      lvl_cmd.push |-> (lvl_stat.count < sara_pkg::LEVEL_SLOTS))
      else $error("quadrant pushed onto a full level");

   a_split_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sara_pkg::ST_SPLIT) |-> (lev_ff >= need_ff && lev_ff < TOP_LEVEL))
      else $error("split level outside the requested range");
`endif

endmodule

/* hdl/sara_slot_ram.sv */
// Corner memory holding the free-list entries of every level, one read and one write port.
`timescale 1ns / 1ps

module sara_slot_ram #(
   parameter int ATLAS_LEVELS = 10
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [$clog2(ATLAS_LEVELS + 1)+1:0]   wr_addr,
   input  logic [2*ATLAS_LEVELS-1:0]             wr_data,
   input  logic                                  rd_en,
   input  logic [$clog2(ATLAS_LEVELS + 1)+1:0]   rd_addr,
   output logic [2*ATLAS_LEVELS-1:0]             rd_data
);

   localparam int DEPTH = (ATLAS_LEVELS + 1) * 4;

   logic [2*ATLAS_LEVELS-1:0] mem [0:DEPTH-1];
   logic [2*ATLAS_LEVELS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/sara_level_table.sv */
// Per-level ring pointers and fill counts of the free lists.
`timescale 1ns / 1ps

module sara_level_table #(
   parameter int ATLAS_LEVELS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sara_pkg::lvl_cmd_type               cmd,
   input  logic [$clog2(ATLAS_LEVELS + 1)-1:0] lvl_idx,
   output sara_pkg::lvl_stat_type              stat
);

   logic [sara_pkg::CNT_W-1:0] cnt_ff  [0:ATLAS_LEVELS];
   logic [sara_pkg::CNT_W-1:0] head_ff [0:ATLAS_LEVELS];
   logic [sara_pkg::CNT_W-1:0] cur_cnt;
   logic [sara_pkg::CNT_W-1:0] cur_head;
   logic [sara_pkg::CNT_W:0]   ring_sum;

   assign cur_cnt  = cnt_ff[lvl_idx];
   assign cur_head = head_ff[lvl_idx];
   assign ring_sum = {1'b0, cur_head} + {1'b0, cur_cnt};

   always_comb begin
      stat.empty = (cur_cnt == '0);
      stat.head  = cur_head;
      stat.count = cur_cnt;
      // Slot index after the youngest entry, modulo the list capacity.
      if (ring_sum >= {1'b0, sara_pkg::LEVEL_SLOTS}) begin
         stat.tail = sara_pkg::CNT_W'(ring_sum - {1'b0, sara_pkg::LEVEL_SLOTS});
      end else begin
         stat.tail = sara_pkg::CNT_W'(ring_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i <= ATLAS_LEVELS; i++) begin
            cnt_ff[i]  <= (i == ATLAS_LEVELS) ? sara_pkg::CNT_W'(1) : '0;
            head_ff[i] <= '0;
         end
      end else if (cmd.pop) begin
         cnt_ff[lvl_idx]  <= cur_cnt - sara_pkg::CNT_W'(1);
         head_ff[lvl_idx] <= (cur_head == sara_pkg::LEVEL_SLOTS - sara_pkg::CNT_W'(1)) ?
                             '0 : cur_head + sara_pkg::CNT_W'(1);
      end else if (cmd.push && (cur_cnt < sara_pkg::LEVEL_SLOTS)) begin
         cnt_ff[lvl_idx] <= cur_cnt + sara_pkg::CNT_W'(1);
      end
   end

endmodule
